@@ sv/ltdg_pkg.sv @@
// ----------------------------------------------------------------------------
// ltdg_pkg
// Shared types and constants for the load threshold clock governor.
// ----------------------------------------------------------------------------
package ltdg_pkg;

	localparam int CFG_INDEX_W      = 3;
	localparam int CFG_DATA_W       = 12;
	localparam int COUNTER_BITS_DEF = 32;
	localparam int REPORT_W         = 32;

	localparam logic [9:0]  PERMILLE_MAX     = 10'd1000;
	localparam logic [5:0]  IDLE_WINDOWS_MAX = 6'd60;
	localparam logic [5:0]  IDLE_RUN_MAX     = 6'd63;

	localparam logic        ENABLED_RST      = 1'b1;
	localparam logic [9:0]  BUSY_HIGH_RST    = 10'd200;
	localparam logic [9:0]  BUSY_LOW_RST     = 10'd80;
	localparam logic [5:0]  IDLE_WINDOWS_RST = 6'd3;
	localparam logic [11:0] MIN_MHZ_RST      = 12'd600;
	localparam logic [11:0] MAX_MHZ_RST      = 12'd1000;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_ENABLED      = 3'd0,
		CFG_BUSY_HIGH    = 3'd1,
		CFG_BUSY_LOW     = 3'd2,
		CFG_IDLE_WINDOWS = 3'd3,
		CFG_MIN_MHZ      = 3'd4,
		CFG_MAX_MHZ      = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic        enabled;
		logic [9:0]  busy_high;
		logic [9:0]  busy_low;
		logic [5:0]  idle_windows;
		logic [11:0] min_mhz;
		logic [11:0] max_mhz;
	} cfg_t;

endpackage

@@ sv/ltdg_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// ltdg_cfg_regs
// Configuration register file; writes out of the legal range are dropped.
// ----------------------------------------------------------------------------
module ltdg_cfg_regs
	import ltdg_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output cfg_t                   cfg
);

	cfg_t cfg_q;
	logic wr;

	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid && cfg_ready;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled      <= ENABLED_RST;
			cfg_q.busy_high    <= BUSY_HIGH_RST;
			cfg_q.busy_low     <= BUSY_LOW_RST;
			cfg_q.idle_windows <= IDLE_WINDOWS_RST;
			cfg_q.min_mhz      <= MIN_MHZ_RST;
			cfg_q.max_mhz      <= MAX_MHZ_RST;
		end else if (wr) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ENABLED: begin
					cfg_q.enabled <= cfg_data[0];
				end
				CFG_BUSY_HIGH: begin
					if (cfg_data[9:0] inside {[10'd1:PERMILLE_MAX]})
						cfg_q.busy_high <= cfg_data[9:0];
				end
				CFG_BUSY_LOW: begin
					if (cfg_data[9:0] inside {[10'd1:PERMILLE_MAX]})
						cfg_q.busy_low <= cfg_data[9:0];
				end
				CFG_IDLE_WINDOWS: begin
					if (cfg_data[5:0] inside {[6'd1:IDLE_WINDOWS_MAX]})
						cfg_q.idle_windows <= cfg_data[5:0];
				end
				CFG_MIN_MHZ: begin
					cfg_q.min_mhz <= cfg_data[11:0];
				end
				CFG_MAX_MHZ: begin
					cfg_q.max_mhz <= cfg_data[11:0];
				end
				default: begin
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_busy_high_range: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_q.busy_high != 10'd0 && cfg_q.busy_high <= PERMILLE_MAX)
		else $error("busy_high out of range");
	a_busy_low_range: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_q.busy_low != 10'd0 && cfg_q.busy_low <= PERMILLE_MAX)
		else $error("busy_low out of range");
	a_idle_windows_range: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_q.idle_windows != 6'd0 && cfg_q.idle_windows <= IDLE_WINDOWS_MAX)
		else $error("idle_windows out of range");
`endif

endmodule

@@ sv/load_threshold_dvfs_governor_top.sv @@
// ----------------------------------------------------------------------------
// load_threshold_dvfs_governor_top
// Threshold clock governor with hysteresis, one load window per input beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one beat per finished load window,
//   carrying busy_permille, busy_valid and last_request_ok.
//   Output channel (out_valid / out_stall): exactly one result beat per input
//   beat, in order, with the decision, an optional clock request and stats.
//   Config channel (cfg_valid / cfg_ready): cfg_ready is always high; write
//   only while no window is in flight.
//   Path: an accepted beat lands in the input register, and its result is
//   then written into the output register when it advances.
//   Throughput: one beat per cycle while out_stall is low; the governor state
//   is updated in a single pass between the input and output registers.
//   Stall: the output register holds while out_stall is high; the input
//   register then stays full and in_stall rises, so no beat is lost.
//   Reset: arst_n clears both stages, the counters and statistics, and
//   loads the configuration defaults; the target starts at 1000 MHz.
// ----------------------------------------------------------------------------
module load_threshold_dvfs_governor_top
	import ltdg_pkg::*;
#(
	parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [9:0]             busy_permille,
	input  logic                   busy_valid,
	input  logic                   last_request_ok,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [11:0]            target_freq,
	output logic                   request_valid,
	output logic [11:0]            request_mhz,
	output logic [5:0]             idle_count,
	output logic [9:0]             last_busy,
	output logic [9:0]             busy_floor,
	output logic [9:0]             busy_peak,
	output logic [REPORT_W-1:0]    window_count,
	output logic [REPORT_W-1:0]    applied_count,
	output logic [REPORT_W-1:0]    failed_count
);

	cfg_t cfg;

	ltdg_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// input register
	logic       vld_s1;
	logic [9:0] busy_s1;
	logic       busy_vld_s1;
	logic       ok_s1;

	// governor state
	logic [11:0]             target_q;
	logic [5:0]              idle_q;
	logic [11:0]             applied_mhz_q;
	logic                    pending_q;
	logic [11:0]             pending_mhz_q;
	logic [9:0]              last_busy_q;
	logic [9:0]              busy_min_q;
	logic [9:0]              busy_max_q;
	logic [COUNTER_BITS-1:0] windows_q;
	logic [COUNTER_BITS-1:0] applied_q;
	logic [COUNTER_BITS-1:0] failed_q;

	// output register
	logic        out_vld_q;
	logic        req_vld_q;
	logic [11:0] req_mhz_q;

	logic in_acc;
	logic adv;

	assign adv      = vld_s1 && (!out_vld_q || !out_stall);
	assign in_stall = vld_s1 && out_vld_q && out_stall;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_acc) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			busy_s1     <= busy_permille;
			busy_vld_s1 <= busy_valid;
			ok_s1       <= last_request_ok;
		end
	end

	// next-state logic
	logic [9:0]              busy_c;
	logic [9:0]              hi_thr;
	logic [5:0]              idle_inc;
	logic [11:0]             applied_mhz_d;
	logic [11:0]             want;
	logic [5:0]              idle_d;
	logic                    req;
	logic                    ack_ok;
	logic                    ack_fail;

	always_comb begin
		busy_c   = (busy_s1 > PERMILLE_MAX) ? PERMILLE_MAX : busy_s1;
		hi_thr   = (cfg.busy_high <= cfg.busy_low) ? cfg.busy_low + 10'd1 : cfg.busy_high;
		idle_inc = (idle_q == IDLE_RUN_MAX) ? IDLE_RUN_MAX : idle_q + 6'd1;
		ack_ok   = pending_q && ok_s1;
		ack_fail = pending_q && !ok_s1;
		applied_mhz_d = ack_ok ? pending_mhz_q : applied_mhz_q;
		want   = target_q;
		idle_d = idle_q;
		if (busy_vld_s1) begin
			if (busy_c > hi_thr) begin
				want   = cfg.max_mhz;
				idle_d = '0;
			end else if (busy_c < cfg.busy_low) begin
				idle_d = idle_inc;
				if (idle_inc >= cfg.idle_windows)
					want = cfg.min_mhz;
			end else begin
				idle_d = '0;
			end
		end
		req = busy_vld_s1 && cfg.enabled && (want != applied_mhz_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q      <= MAX_MHZ_RST;
			idle_q        <= '0;
			applied_mhz_q <= '0;
			pending_q     <= 1'b0;
			pending_mhz_q <= '0;
			last_busy_q   <= '0;
			busy_min_q    <= PERMILLE_MAX;
			busy_max_q    <= '0;
			windows_q     <= '0;
			applied_q     <= '0;
			failed_q      <= '0;
			out_vld_q     <= 1'b0;
			req_vld_q     <= 1'b0;
			req_mhz_q     <= '0;
		end else begin
			if (adv) begin
				target_q      <= want;
				idle_q        <= idle_d;
				applied_mhz_q <= applied_mhz_d;
				pending_q     <= req;
				if (req)
					pending_mhz_q <= want;
				if (busy_vld_s1) begin
					last_busy_q <= busy_c;
					if (busy_c < busy_min_q)
						busy_min_q <= busy_c;
					if (busy_c > busy_max_q)
						busy_max_q <= busy_c;
				end
				if (windows_q != '1)
					windows_q <= windows_q + 1'b1;
				if (ack_ok && applied_q != '1)
					applied_q <= applied_q + 1'b1;
				if (ack_fail && failed_q != '1)
					failed_q <= failed_q + 1'b1;
				req_vld_q <= req;
				req_mhz_q <= req ? want : 12'd0;
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_vld_q;
	assign target_freq   = target_q;
	assign request_valid = req_vld_q;
	assign request_mhz   = req_mhz_q;
	assign idle_count    = idle_q;
	assign last_busy     = last_busy_q;
	assign busy_floor    = busy_min_q;
	assign busy_peak     = busy_max_q;
	assign window_count  = REPORT_W'(windows_q);
	assign applied_count = REPORT_W'(applied_q);
	assign failed_count  = REPORT_W'(failed_q);

`ifndef SYNTHESIS
	a_req_matches_target: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && req_vld_q |-> req_mhz_q == target_q && pending_q)
		else $error("request beat does not match target");
	a_pending_from_req: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pending_q) |-> out_vld_q && req_vld_q)
		else $error("pending set without a request beat");
	a_windows_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		windows_q >= $past(windows_q))
		else $error("window counter went backwards");
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_stall |=> out_vld_q && $stable(target_q) && $stable(windows_q))
		else $error("result changed while stalled");
`endif

endmodule
